FILE: hw/rtl/aces_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aces_pkg
// Types, codes and helpers shared by the angle compare event scheduler.
// ----------------------------------------------------------------------------
package aces_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [31:0] ANGLE_MASK = 32'h0000_FFFF;
    localparam logic [31:0] REV_MASK   = 32'hFFFF_0000;
    localparam logic [31:0] ONE_REV    = 32'h0001_0000;

    typedef enum logic [1:0] {
        OP_REG_REL = 2'd0,
        OP_REG_ABS = 2'd1,
        OP_COMPARE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_ONCE     = 2'd1,
        MODE_PERIODIC = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } state_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] cur_position;
        logic [31:0] target_angle;
        logic [7:0]  event_tag;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  slot_index;
        logic        compare_set;
        logic [31:0] cmp_target;
        logic        fired;
        logic [7:0]  fired_tag;
    } result_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        op_t               op;
        logic [31:0]       pos;
        logic [31:0]       new_target;
        logic [7:0]        tag;
        logic [SLOT_W-1:0] cur_slot;
        logic              cur_present;
    } cell_cmd_t;

    // scan token that walks the row of cells
    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
        mode_t             cur_mode;
        logic [31:0]       cur_target;
        logic              have;
        logic [SLOT_W-1:0] best_idx;
        logic [31:0]       best_target;
        logic              fired;
        logic [7:0]        fired_tag;
    } scan_tok_t;

    function automatic logic nearer_ahead(logic [31:0] p, logic [31:0] c, logic [31:0] n);
        return ((c > p) && (n < c) && (n > p)) || ((c < p) && (n < c)) || ((c < p) && (n > p));
    endfunction

    function automatic logic [2:0] to_slot_index(logic [SLOT_W-1:0] idx);
        logic [SLOT_W+2:0] wide;
        wide = {3'b000, idx};
        return wide[2:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aces_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aces_cell
// One compare slot: holds mode, target and tag, and updates the scan token
// as it passes on to the next slot.
// ----------------------------------------------------------------------------
module aces_cell
    import aces_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_cmd_t cmd,
    input  wire logic      tok_in_valid,
    input  wire scan_tok_t tok_in,
    output logic           tok_out_valid,
    output scan_tok_t      tok_out
);

    mode_t       mode_reg, mode_next;
    logic [31:0] target_reg, target_next;
    logic [7:0]  tag_reg, tag_next;
    logic        tok_valid_reg;
    scan_tok_t   tok_reg, tok_next;

    mode_t       eff_mode;
    logic [31:0] eff_target;
    logic        is_cur;

    always_comb begin
        tok_next    = tok_in;
        mode_next   = mode_reg;
        target_next = target_reg;
        tag_next    = tag_reg;
        eff_mode    = mode_reg;
        eff_target  = target_reg;
        is_cur      = cmd.cur_present && (tok_in.idx == cmd.cur_slot);
        tok_next.idx = tok_in.idx + SLOT_W'(1);
        if (tok_in_valid) begin
            case (cmd.op)
                OP_REG_REL, OP_REG_ABS: begin
                    // current slot seen before any write
                    if (tok_in.idx == cmd.cur_slot) begin
                        tok_next.cur_mode   = mode_reg;
                        tok_next.cur_target = target_reg;
                    end
                    if (!tok_in.free_found && (mode_reg == MODE_OFF)) begin
                        mode_next           = (cmd.op == OP_REG_REL) ? MODE_PERIODIC : MODE_ONCE;
                        target_next         = cmd.new_target;
                        tag_next            = cmd.tag;
                        tok_next.free_found = 1'b1;
                        tok_next.free_idx   = tok_in.idx;
                    end
                end
                OP_COMPARE: begin
                    if (is_cur && (mode_reg != MODE_OFF)) begin
                        tok_next.fired     = 1'b1;
                        tok_next.fired_tag = tag_reg;
                        if (mode_reg == MODE_PERIODIC) begin
                            eff_target = target_reg + ONE_REV;
                        end else begin
                            eff_mode = MODE_OFF;
                        end
                    end
                    if ((eff_mode != MODE_OFF) &&
                        (!tok_in.have || nearer_ahead(cmd.pos, tok_in.best_target, eff_target))) begin
                        tok_next.have        = 1'b1;
                        tok_next.best_idx    = tok_in.idx;
                        tok_next.best_target = eff_target;
                    end
                    mode_next   = eff_mode;
                    target_next = eff_target;
                end
                OP_CLEAR: begin
                    mode_next = MODE_OFF;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_OFF;
            tok_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg <= target_next;
        tag_reg    <= tag_next;
        if (tok_in_valid) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/angle_compare_event_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// angle_compare_event_scheduler_top
// Compare slot table as a row of cells; every item sends one scan token
// down the row, then the current target and the result are settled.
// ----------------------------------------------------------------------------
// result: registered once the scan token has walked the row of slot cells
//   one slot per cycle and the result is settled; the output register holds
//   while m_ready is low, and no new item is taken until the result is loaded
// reset: synchronous active-low aresetn; all slots inactive, current slot is
//   the last slot and marked present, no result pending
module angle_compare_event_scheduler_top
    import aces_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire item_t   s_item,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_result
);

    state_t            state_reg, state_next;
    logic              go_reg;
    item_t             item_reg;
    logic [31:0]       proj_target;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic              cur_present_reg, cur_present_next;
    logic              m_valid_reg;
    result_t           m_result_reg, res;
    logic              out_load;
    logic              in_accept;

    cell_cmd_t         cmd;
    scan_tok_t         start_tok;
    scan_tok_t         tok_chain [SLOTS];
    logic              vld_chain [SLOTS];
    scan_tok_t         last_tok;
    logic              last_vld;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_result  = m_result_reg;

    // relative target: next crossing of the angle
    always_comb begin
        proj_target = (item_reg.cur_position & REV_MASK) | (item_reg.target_angle & ANGLE_MASK);
        if ((item_reg.cur_position & ANGLE_MASK) > (item_reg.target_angle & ANGLE_MASK)) begin
            proj_target = proj_target + ONE_REV;
        end
    end

    always_comb begin
        cmd.op          = item_reg.operation;
        cmd.pos         = item_reg.cur_position;
        cmd.new_target  = (item_reg.operation == OP_REG_REL) ? proj_target
                                                             : item_reg.target_angle;
        cmd.tag         = item_reg.event_tag;
        cmd.cur_slot    = cur_slot_reg;
        cmd.cur_present = cur_present_reg;
    end

    always_comb begin
        start_tok             = '0;
        start_tok.cur_mode    = MODE_OFF;
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        if (i == 0) begin : g_head
            aces_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .cmd           (cmd),
                .tok_in_valid  (go_reg),
                .tok_in        (start_tok),
                .tok_out_valid (vld_chain[i]),
                .tok_out       (tok_chain[i])
            );
        end else begin : g_body
            aces_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .cmd           (cmd),
                .tok_in_valid  (vld_chain[i-1]),
                .tok_in        (tok_chain[i-1]),
                .tok_out_valid (vld_chain[i]),
                .tok_out       (tok_chain[i])
            );
        end
    end

    assign last_tok = tok_chain[SLOTS-1];
    assign last_vld = vld_chain[SLOTS-1];

    // settle result and current target from the finished token
    always_comb begin
        res              = '0;
        cur_slot_next    = cur_slot_reg;
        cur_present_next = cur_present_reg;
        case (item_reg.operation)
            OP_REG_REL, OP_REG_ABS: begin
                res.accepted   = last_tok.free_found;
                res.slot_index = last_tok.free_found ? to_slot_index(last_tok.free_idx) : 3'd0;
                if (last_tok.free_found &&
                    (!cur_present_reg ||
                     ((cur_slot_reg != last_tok.free_idx) &&
                      ((last_tok.cur_mode == MODE_OFF) ||
                       nearer_ahead(item_reg.cur_position, last_tok.cur_target,
                                    cmd.new_target))))) begin
                    cur_slot_next    = last_tok.free_idx;
                    cur_present_next = 1'b1;
                    res.compare_set  = 1'b1;
                    res.cmp_target   = cmd.new_target;
                end
            end
            OP_COMPARE: begin
                res.accepted  = 1'b1;
                res.fired     = last_tok.fired;
                res.fired_tag = last_tok.fired_tag;
                if (last_tok.have) begin
                    cur_slot_next    = last_tok.best_idx;
                    cur_present_next = 1'b1;
                    res.compare_set  = 1'b1;
                    res.cmp_target   = last_tok.best_target;
                end
            end
            OP_CLEAR: begin
                res.accepted     = 1'b1;
                cur_present_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_vld) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            go_reg          <= 1'b0;
            cur_slot_reg    <= SLOT_W'(SLOTS - 1);
            cur_present_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= in_accept;
            if (out_load) begin
                cur_slot_reg    <= cur_slot_next;
                cur_present_reg <= cur_present_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            item_reg <= s_item;
        end
        if (out_load) begin
            m_result_reg <= res;
        end
    end

    a_idle_no_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !last_vld)
        else $error("scan token left the row while idle");

    a_token_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        last_vld |-> (state_reg == S_SCAN))
        else $error("scan token finished outside a scan");

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (go_reg && (state_reg == S_SCAN)))
        else $error("accepted item did not start a scan");

    a_clear_drops_current: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (item_reg.operation == OP_CLEAR)) |=> !cur_present_reg)
        else $error("clear left a current slot");

    a_set_marks_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res.compare_set) |=> cur_present_reg)
        else $error("issued compare target without a current slot");

endmodule
`default_nettype wire
